// ===== design/qrs_pkg.sv =====
// Shared widths and result class codes for the quadratic root solver.
`timescale 1ns / 1ps

package qrs_pkg;

  localparam int DISC_W = 40;
  localparam int ROOT_W = 32;
  localparam int KIND_W = 3;

  // Equation classes reported on out_kind
  localparam logic [KIND_W-1:0] KIND_NONE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LINEAR = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NEG    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DOUBLE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TWO    = 3'd4;

endpackage

// ===== design/quadratic_root_solver.sv =====
// Pipelined classifier and real-root solver for a*x^2 + b*x + c = 0.
//
// Usage:
//   Present coefficients on in_coef_a/b/c (signed fixed point, FRAC_BITS
//   fraction bits) and raise start; a beat is taken at each clock edge with
//   start high and busy low. busy is only high during reset, so a new beat
//   can be taken every cycle.
//   Each beat produces exactly one result, shown for one cycle with
//   out_valid high: class, discriminant b^2-4ac, two roots and a
//   saturation flag. Results leave in the order the beats came in.
//   Throughput is one beat per cycle. The square root pipeline (one root
//   bit per stage, COEF_WIDTH+1 stages) is followed by the restoring
//   dividers (one quotient bit per stage, COEF_WIDTH+2+FRAC_BITS stages);
//   two dividers run side by side, one per root.
//   The receiver cannot stall, so nothing ever backs up inside.
//   Synchronous reset clears every valid bit; beats in flight are dropped.
`timescale 1ns / 1ps

module quadratic_root_solver
  import qrs_pkg::*;
#(
  parameter int COEF_WIDTH = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COEF_WIDTH-1:0] in_coef_a,
  input  logic signed [COEF_WIDTH-1:0] in_coef_b,
  input  logic signed [COEF_WIDTH-1:0] in_coef_c,
  output logic                         out_valid,
  output logic        [KIND_W-1:0]     out_kind,
  output logic signed [DISC_W-1:0]     out_discriminant,
  output logic signed [ROOT_W-1:0]     out_root_one,
  output logic signed [ROOT_W-1:0]     out_root_two,
  output logic                         out_saturated
);

  localparam int CW   = COEF_WIDTH;
  localparam int FB   = FRAC_BITS;
  localparam int PW   = 2 * CW;           // product width
  localparam int DXW  = 2 * CW + 3;       // exact discriminant
  localparam int SQW  = CW + 1;           // square root width
  localparam int XW   = 2 * SQW;          // radicand width
  localparam int REMW = SQW + 2;          // sqrt remainder
  localparam int NSW  = CW + 3;           // signed numerator / denominator
  localparam int NW   = NSW - 1;          // numerator magnitude
  localparam int DW   = CW + 1;           // denominator magnitude
  localparam int QW   = NW + FB;          // quotient / dividend width
  localparam int QX   = (QW > ROOT_W + 1) ? QW : ROOT_W + 1;
  localparam logic [QX-1:0] QMAX = (QX'(1) << (ROOT_W - 1)) - QX'(1);
  localparam logic [QX-1:0] QMIN = QX'(1) << (ROOT_W - 1);

  typedef struct packed {
    logic signed [CW-1:0]     a;
    logic signed [CW-1:0]     b;
    logic signed [CW-1:0]     c;
    logic        [KIND_W-1:0] kind;
    logic signed [DISC_W-1:0] disc;
  } side_t;

  typedef struct packed {
    logic        [KIND_W-1:0] kind;
    logic signed [DISC_W-1:0] disc;
    logic                     neg1;
    logic                     neg2;
  } dside_t;

  // saturate a quotient magnitude with its sign; returns {sat, root}
  function automatic logic [ROOT_W:0] sat_root(input logic [QW-1:0] q, input logic neg);
    logic [QX-1:0] qx;
    logic [ROOT_W:0] res;
    qx = QX'(q);
    if (!neg) begin
      if (qx > QMAX) res = {1'b1, QMAX[ROOT_W-1:0]};
      else res = {1'b0, qx[ROOT_W-1:0]};
    end else begin
      if (qx > QMIN) res = {1'b1, QMIN[ROOT_W-1:0]};
      else res = {1'b0, ROOT_W'(-qx[ROOT_W-1:0])};
    end
    return res;
  endfunction

  assign busy = ~rst_n;

  // stage 0: input register
  logic                 s0_v_r;
  logic signed [CW-1:0] s0_a_r, s0_b_r, s0_c_r;
  // stage 1: products
  logic                 s1_v_r;
  logic signed [CW-1:0] s1_a_r, s1_b_r, s1_c_r;
  logic signed [PW-1:0] s1_bb_r, s1_ac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else begin
      s0_v_r <= start & ~busy;
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s0_a_r  <= in_coef_a;
    s0_b_r  <= in_coef_b;
    s0_c_r  <= in_coef_c;
    s1_a_r  <= s0_a_r;
    s1_b_r  <= s0_b_r;
    s1_c_r  <= s0_c_r;
    s1_bb_r <= s0_b_r * s0_b_r;
    s1_ac_r <= s0_a_r * s0_c_r;
  end

  // stage 2: discriminant, class, radicand magnitude
  logic signed [DXW-1:0] dx;
  logic        [DXW-1:0] dmag;
  side_t                 side_nxt;

  assign dx   = DXW'(s1_bb_r) - (DXW'(s1_ac_r) <<< 2);
  assign dmag = dx[DXW-1] ? DXW'(-dx) : DXW'(dx);

  always_comb begin
    side_nxt.a    = s1_a_r;
    side_nxt.b    = s1_b_r;
    side_nxt.c    = s1_c_r;
    side_nxt.disc = DISC_W'(dx >>> FB);
    if (s1_a_r == '0) begin
      side_nxt.disc = '0;
      side_nxt.kind = (s1_b_r == '0) ? KIND_NONE : KIND_LINEAR;
    end else if (dx[DXW-1]) begin
      side_nxt.kind = KIND_NEG;
    end else if (dx == '0) begin
      side_nxt.kind = KIND_DOUBLE;
    end else begin
      side_nxt.kind = KIND_TWO;
    end
  end

  // square root pipeline, one root bit per stage; index 0 is stage 2
  logic              sq_v_r    [0:SQW];
  logic [XW-1:0]     sq_x_r    [0:SQW];
  logic [REMW-1:0]   sq_rem_r  [0:SQW];
  logic [SQW-1:0]    sq_root_r [0:SQW];
  side_t             sq_side_r [0:SQW];

  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r[0] <= 1'b0;
    else sq_v_r[0] <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    sq_x_r[0]    <= dmag[XW-1:0];
    sq_rem_r[0]  <= '0;
    sq_root_r[0] <= '0;
    sq_side_r[0] <= side_nxt;
  end

  for (genvar k = 0; k < SQW; k++) begin : g_sqrt
    logic [REMW+1:0] rs;
    logic [REMW+1:0] trial;
    logic            take;

    assign rs    = {sq_rem_r[k], sq_x_r[k][XW-1:XW-2]};
    assign trial = (REMW + 2)'({sq_root_r[k], 2'b01});
    assign take  = (rs >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[k+1] <= 1'b0;
      else sq_v_r[k+1] <= sq_v_r[k];
    end

    always_ff @(posedge clk) begin
      sq_x_r[k+1]    <= {sq_x_r[k][XW-3:0], 2'b00};
      sq_rem_r[k+1]  <= take ? REMW'(rs - trial) : REMW'(rs);
      sq_root_r[k+1] <= {sq_root_r[k][SQW-2:0], take};
      sq_side_r[k+1] <= sq_side_r[k];
    end
  end

  // divider set-up: numerators and denominator as magnitude and sign
  side_t                 ps;
  logic                  lin;
  logic signed [NSW-1:0] ax, bx, cx, sx, n1, n2, den;
  logic        [NSW-1:0] n1m, n2m, denm;
  dside_t                dside_nxt;

  assign ps   = sq_side_r[SQW];
  assign lin  = (ps.kind == KIND_LINEAR);
  assign ax   = NSW'(ps.a);
  assign bx   = NSW'(ps.b);
  assign cx   = NSW'(ps.c);
  assign sx   = signed'(NSW'(sq_root_r[SQW]));
  assign n1   = lin ? -cx : (sx - bx);
  assign n2   = -bx - sx;
  assign den  = lin ? bx : (ax <<< 1);
  assign n1m  = n1[NSW-1] ? NSW'(-n1) : NSW'(n1);
  assign n2m  = n2[NSW-1] ? NSW'(-n2) : NSW'(n2);
  assign denm = den[NSW-1] ? NSW'(-den) : NSW'(den);

  always_comb begin
    dside_nxt.kind = ps.kind;
    dside_nxt.disc = ps.disc;
    dside_nxt.neg1 = n1[NSW-1] ^ den[NSW-1];
    dside_nxt.neg2 = n2[NSW-1] ^ den[NSW-1];
  end

  // two restoring dividers, one quotient bit per stage; index 0 is set-up
  logic           dv_v_r    [0:QW];
  logic [QW-1:0]  dv_n1_r   [0:QW];
  logic [QW-1:0]  dv_n2_r   [0:QW];
  logic [DW-1:0]  dv_r1_r   [0:QW];
  logic [DW-1:0]  dv_r2_r   [0:QW];
  logic [QW-1:0]  dv_q1_r   [0:QW];
  logic [QW-1:0]  dv_q2_r   [0:QW];
  logic [DW-1:0]  dv_den_r  [0:QW];
  dside_t         dv_side_r [0:QW];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else dv_v_r[0] <= sq_v_r[SQW];
  end

  always_ff @(posedge clk) begin
    dv_n1_r[0]   <= {n1m[NW-1:0], {FB{1'b0}}};
    dv_n2_r[0]   <= {n2m[NW-1:0], {FB{1'b0}}};
    dv_r1_r[0]   <= '0;
    dv_r2_r[0]   <= '0;
    dv_q1_r[0]   <= '0;
    dv_q2_r[0]   <= '0;
    dv_den_r[0]  <= denm[DW-1:0];
    dv_side_r[0] <= dside_nxt;
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [DW:0] rs1, rs2, dd;
    logic        t1, t2;

    assign dd  = {1'b0, dv_den_r[j]};
    assign rs1 = {dv_r1_r[j], dv_n1_r[j][QW-1]};
    assign rs2 = {dv_r2_r[j], dv_n2_r[j][QW-1]};
    assign t1  = (rs1 >= dd);
    assign t2  = (rs2 >= dd);

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[j+1] <= 1'b0;
      else dv_v_r[j+1] <= dv_v_r[j];
    end

    always_ff @(posedge clk) begin
      dv_n1_r[j+1]   <= {dv_n1_r[j][QW-2:0], 1'b0};
      dv_n2_r[j+1]   <= {dv_n2_r[j][QW-2:0], 1'b0};
      dv_r1_r[j+1]   <= t1 ? DW'(rs1 - dd) : DW'(rs1);
      dv_r2_r[j+1]   <= t2 ? DW'(rs2 - dd) : DW'(rs2);
      dv_q1_r[j+1]   <= {dv_q1_r[j][QW-2:0], t1};
      dv_q2_r[j+1]   <= {dv_q2_r[j][QW-2:0], t2};
      dv_den_r[j+1]  <= dv_den_r[j];
      dv_side_r[j+1] <= dv_side_r[j];
    end
  end

  // output stage: saturate and select fields by class
  dside_t            fs;
  logic [ROOT_W:0]   sr1, sr2;
  logic [KIND_W-1:0] kind_nxt;
  logic [DISC_W-1:0] disc_nxt;
  logic [ROOT_W-1:0] r1_nxt, r2_nxt;
  logic              sat_nxt;
  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [DISC_W-1:0] out_disc_r;
  logic [ROOT_W-1:0] out_r1_r, out_r2_r;
  logic              out_sat_r;

  assign fs  = dv_side_r[QW];
  assign sr1 = sat_root(dv_q1_r[QW], fs.neg1);
  assign sr2 = sat_root(dv_q2_r[QW], fs.neg2);

  always_comb begin
    kind_nxt = fs.kind;
    disc_nxt = fs.disc;
    r1_nxt   = '0;
    r2_nxt   = '0;
    sat_nxt  = 1'b0;
    case (fs.kind) inside
      KIND_LINEAR: begin
        r1_nxt  = sr1[ROOT_W-1:0];
        sat_nxt = sr1[ROOT_W];
      end
      KIND_DOUBLE, KIND_TWO: begin
        r1_nxt  = sr1[ROOT_W-1:0];
        r2_nxt  = sr2[ROOT_W-1:0];
        sat_nxt = sr1[ROOT_W] | sr2[ROOT_W];
      end
      default: begin
        r1_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= dv_v_r[QW];
  end

  always_ff @(posedge clk) begin
    out_kind_r <= kind_nxt;
    out_disc_r <= disc_nxt;
    out_r1_r   <= r1_nxt;
    out_r2_r   <= r2_nxt;
    out_sat_r  <= sat_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_discriminant = signed'(out_disc_r);
  assign out_root_one     = signed'(out_r1_r);
  assign out_root_two     = signed'(out_r2_r);
  assign out_saturated    = out_sat_r;

endmodule

// ===== design/qrs_checker.sv =====
// Port-level checks for the quadratic root solver, bound to the top level.
`timescale 1ns / 1ps

module qrs_checker
  import qrs_pkg::*;
#(
  parameter int COEF_WIDTH = 24,
  parameter int FRAC_BITS  = 16
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic        [KIND_W-1:0]     out_kind,
  input logic signed [DISC_W-1:0]     out_discriminant,
  input logic signed [ROOT_W-1:0]     out_root_one,
  input logic signed [ROOT_W-1:0]     out_root_two,
  input logic                         out_saturated
);

  localparam int LAT = 2 * COEF_WIDTH + FRAC_BITS + 8;
  localparam int CNTW = $clog2(LAT + 1);

  // cycles since reset, saturating at the pipeline depth
  logic [CNTW-1:0] warm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) warm_r <= '0;
    else if (warm_r != CNTW'(LAT)) warm_r <= warm_r + 1'b1;
  end

  // result strobes match accepted beats one for one once the pipeline has filled
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (warm_r == CNTW'(LAT)) |-> (out_valid == $past(start && !busy, LAT)))
    else $error("result strobe does not match accepted beat");

  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_NONE) |->
      (out_discriminant == '0 && out_root_one == '0 && out_root_two == '0
       && !out_saturated))
    else $error("no-equation result carries data");

  a_linear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_LINEAR) |->
      (out_discriminant == '0 && out_root_two == '0))
    else $error("linear result has discriminant or second root");

  a_negative: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_NEG) |->
      (out_discriminant < 0 && out_root_one == '0 && out_root_two == '0
       && !out_saturated))
    else $error("complex-root result malformed");

  a_double: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_DOUBLE) |->
      (out_root_one == out_root_two && out_discriminant == '0))
    else $error("double root mismatch");

endmodule

bind quadratic_root_solver qrs_checker #(
  .COEF_WIDTH(COEF_WIDTH),
  .FRAC_BITS (FRAC_BITS)
) u_qrs_checker (.*);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the quadratic root solver.
`timescale 1ns / 1ps

module tb_top;
  import qrs_pkg::*;

  localparam int CW        = 24;
  localparam int FB        = 16;
  localparam int LATENCY   = 2 * CW + FB + 8;
  localparam int STALL_MAX = 4000;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DISC_W-1:0] disc;
    logic signed [ROOT_W-1:0] root_one;
    logic signed [ROOT_W-1:0] root_two;
    logic                     sat;
  } solution_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] in_coef_a = '0;
  logic signed [CW-1:0] in_coef_b = '0;
  logic signed [CW-1:0] in_coef_c = '0;
  logic out_valid;
  logic [KIND_W-1:0] out_kind;
  logic signed [DISC_W-1:0] out_discriminant;
  logic signed [ROOT_W-1:0] out_root_one;
  logic signed [ROOT_W-1:0] out_root_two;
  logic out_saturated;

  solution_t pending_solutions[$];
  int errors = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int kind_hits[5] = '{default: 0};
  int sat_hits = 0;
  int idle_pct = 0;
  int quiet_cycles = 0;

  quadratic_root_solver #(.COEF_WIDTH(CW), .FRAC_BITS(FB)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_coef_a(in_coef_a), .in_coef_b(in_coef_b), .in_coef_c(in_coef_c),
    .out_valid(out_valid), .out_kind(out_kind),
    .out_discriminant(out_discriminant), .out_root_one(out_root_one),
    .out_root_two(out_root_two), .out_saturated(out_saturated)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Floor square root, bit by bit
  function automatic longint unsigned floor_sqrt(input longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // num/den in Q16.16, truncated toward zero, clipped to 32 bits
  function automatic logic [ROOT_W-1:0] clipped_quotient(input longint num,
                                                         input longint den,
                                                         inout logic sat);
    longint unsigned q;
    longint unsigned mn;
    longint unsigned md;
    mn = (num < 0) ? -num : num;
    md = (den < 0) ? -den : den;
    q = (mn << FB) / md;
    if ((num < 0) == (den < 0)) begin
      if (q > 64'h7FFF_FFFF) begin
        sat = 1'b1;
        return 32'h7FFF_FFFF;
      end
      return q[31:0];
    end
    if (q > 64'h8000_0000) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return -q[31:0];
  endfunction

  function automatic solution_t solve_quadratic(input logic signed [CW-1:0] ca,
                                                input logic signed [CW-1:0] cb,
                                                input logic signed [CW-1:0] cc);
    solution_t s;
    longint a;
    longint b;
    longint c;
    longint dx;
    longint root_d;
    logic sat;
    a = ca;
    b = cb;
    c = cc;
    sat = 1'b0;
    s = '0;
    if (a == 0) begin
      if (b != 0) begin
        s.kind = KIND_LINEAR;
        s.root_one = clipped_quotient(-c, b, sat);
      end else begin
        s.kind = KIND_NONE;
      end
    end else begin
      dx = b * b - 4 * a * c;
      s.disc = dx >>> FB;
      if (dx < 0) begin
        s.kind = KIND_NEG;
      end else begin
        root_d = floor_sqrt(dx);
        s.root_one = clipped_quotient(-b + root_d, 2 * a, sat);
        if (dx == 0) begin
          s.kind = KIND_DOUBLE;
          s.root_two = s.root_one;
        end else begin
          s.kind = KIND_TWO;
          s.root_two = clipped_quotient(-b - root_d, 2 * a, sat);
        end
      end
    end
    s.sat = sat;
    return s;
  endfunction

  // Present one beat at the falling edge, hold until taken
  task automatic send_beat(input logic signed [CW-1:0] a,
                           input logic signed [CW-1:0] b,
                           input logic signed [CW-1:0] c);
    @(negedge clk);
    start <= 1'b1;
    in_coef_a <= a;
    in_coef_b <= b;
    in_coef_c <= c;
    do @(posedge clk); while (busy);
    pending_solutions.push_back(solve_quadratic(a, b, c));
    beats_sent++;
    // each following cycle idles with probability idle_pct
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Double root: b^2 = 4ac exactly, raw integers
  task automatic send_double_root();
    longint p;
    longint q;
    p = $urandom_range(2047, 1);
    q = $urandom_range(63, 1);
    if ($urandom_range(1)) p = -p;
    if ($urandom_range(1)) q = -q;
    send_beat(CW'(p), CW'(2 * p * q), CW'(p * q * q));
  endtask

  task automatic test_directed_extremes();
    send_beat(0, 0, 0);
    send_beat(0, 0, 24'sh7FFFFF);
    send_beat(0, 0, 24'sh800000);
    send_beat(0, 24'sh010000, 24'sh020000);
    send_beat(0, 24'sh000001, 24'sh7FFFFF);
    send_beat(0, 24'sh000001, 24'sh800000);
    send_beat(0, 24'shFFFFFF, 24'sh800000);
    send_beat(0, 24'sh800000, 24'sh800000);
    send_beat(24'sh010000, 0, 24'sh010000);
    send_beat(24'sh010000, 24'sh020000, 24'sh010000);
    send_beat(24'sh010000, 24'shFD0000, 24'sh020000);
    send_beat(24'sh000001, 24'sh7FFFFF, 0);
    send_beat(24'sh000001, 24'sh800000, 0);
    send_beat(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send_beat(24'sh800000, 24'sh800000, 24'sh800000);
    send_beat(24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF);
    send_beat(24'sh7FFFFF, 24'sh000001, 24'sh800000);
    send_beat(24'sh000001, 24'sh000001, 0);
    send_beat(24'sh000001, 0, 24'shFFFFFF);
    send_beat(24'shFFFFFF, 0, 24'shFFFFFF);
    send_double_root();
    send_double_root();
  endtask

  task automatic test_random_equations(input int n);
    int sel;
    repeat (n) begin
      sel = $urandom_range(99);
      if (sel < 35) begin
        send_beat(CW'($urandom), CW'($urandom), CW'($urandom));
      end else if (sel < 50) begin
        // a limited to -32768..32767, b and c at full range
        send_beat($signed(24'($urandom_range(65535))) - 24'sd32768,
                  CW'($urandom), CW'($urandom));
      end else if (sel < 62) begin
        send_double_root();
      end else if (sel < 76) begin
        // linear, some with tiny b to force clipping
        send_beat(0, CW'(($urandom_range(1) ? $urandom : $urandom_range(15)) | 1),
                  CW'($urandom));
      end else if (sel < 82) begin
        send_beat(0, 0, CW'($urandom));
      end else begin
        // tiny a, large b: roots far out
        send_beat($signed(24'($urandom_range(31))) - 24'sd16,
                  CW'($urandom), CW'($urandom));
      end
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    solution_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_kind <= KIND_TWO) kind_hits[out_kind]++;
      if (out_saturated) sat_hits++;
      if (pending_solutions.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = pending_solutions.pop_front();
        if (out_kind !== want.kind) begin
          $error("kind exp %0d got %0d", want.kind, out_kind); errors++;
        end
        if (out_discriminant !== want.disc) begin
          $error("discriminant exp %0d got %0d", want.disc, out_discriminant); errors++;
        end
        if (out_root_one !== want.root_one) begin
          $error("root_one exp %0d got %0d", want.root_one, out_root_one); errors++;
        end
        if (out_root_two !== want.root_two) begin
          $error("root_two exp %0d got %0d", want.root_two, out_root_two); errors++;
        end
        if (out_saturated !== want.sat) begin
          $error("saturated exp %0d got %0d", want.sat, out_saturated); errors++;
        end
      end
    end
  end

  // Watchdog: no beat taken and no result for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    idle_pct = 22;
    test_directed_extremes();
    test_random_equations(630);
    idle_pct = 88;
    test_random_equations(630);
    idle_pct = 0;
    test_random_equations(640);
    @(negedge clk);
    start <= 1'b0;
    wait (pending_solutions.size() == 0);
    repeat (LATENCY + 8) @(posedge clk);
    $display("Covered %0d beats, %0d results: none %0d, linear %0d, negative %0d,",
             beats_sent, results_seen, kind_hits[0], kind_hits[1], kind_hits[2]);
    $display("  double %0d, two roots %0d, clipped %0d", kind_hits[3], kind_hits[4],
             sat_hits);
    if (errors == 0 && pending_solutions.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
